/* sv/fpba_pkg.sv */
package fpba_pkg;

   localparam int DEF_MAX_BLOCKS   = 64;
   localparam int DEF_HEADER_BYTES = 32;

   localparam int START_W = 32;
   localparam int BYTES_W = 24;
   localparam int NEED_W  = BYTES_W + 1;
   localparam int ENTRY_W = 1 + BYTES_W + START_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 2'd1;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERO    = 2'd1,
      ST_NOMEM   = 2'd2,
      ST_BADFREE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FIN_NONE,
      FIN_ZERO,
      FIN_NOMEM,
      FIN_BADFREE,
      FIN_FREE,
      FIN_REUSE,
      FIN_GROW
   } fin_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FREE_CHK,
      S_SCAN,
      S_PICK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic    load_item;
      logic    scan_start;
      logic    scan_step;
      fin_type fin;
      logic    push_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic free_mode;
      logic zero_req;
      logic oversize;
      logic free_bad;
      logic count_zero;
      logic rd_free;
      logic scan_stop;
      logic scan_last;
      logic pick_valid;
      logic grow_fail;
      logic slot_free;
   } dp_stat_type;

endpackage

/* sv/fpba_channels.sv */
interface fpba_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [23:0] request_size;
   logic [5:0]  free_index;

   modport source (output valid, output mode, output request_size, output free_index,
                   input ready);
   modport sink (input valid, input mode, input request_size, input free_index,
                 output ready);
endinterface

interface fpba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  granted_index;
   logic [31:0] data_offset;
   logic        reused;

   modport source (output valid, output status, output granted_index, output data_offset,
                   output reused, input ready);
   modport sink (input valid, input status, input granted_index, input data_offset,
                 input reused, output ready);
endinterface

interface fpba_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/fpba_ram.sv */
module fpba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/fpba_datapath.sv */
module fpba_datapath
   import fpba_pkg::*;
#(
   parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic                  req_mode,
   input  logic [BYTES_W-1:0]    req_request_size,
   input  logic [5:0]            req_free_index,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [5:0]            rsp_granted_index,
   output logic [START_W-1:0]    rsp_data_offset,
   output logic                  rsp_reused
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int EXT_W = START_W + 2;

   fit_type              policy_ff;
   logic [START_W-1:0]   limit_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [START_W-1:0]   heap_end_ff, heap_end_in;
   logic [IDX_W-1:0]     cursor_ff, cursor_in;

   logic                 mode_ff;
   logic                 zero_ff;
   logic [NEED_W-1:0]    need_ff;
   logic [5:0]           fidx_ff;

   logic [IDX_W-1:0]     chk_pos_ff, chk_pos_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   logic                 pick_valid_ff, pick_valid_in;
   logic [IDX_W-1:0]     pick_idx_ff;
   logic [BYTES_W-1:0]   pick_left_ff, pick_bytes_ff;
   logic [START_W-1:0]   pick_start_ff;

   status_type           res_status_ff, out_status_ff;
   logic [5:0]           res_index_ff, out_index_ff;
   logic [START_W-1:0]   res_offset_ff, out_offset_ff;
   logic                 res_reused_ff, out_reused_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr, scan_origin, scan_next;
   logic [ENTRY_W-1:0]   wr_data, rd_data;
   logic                 rd_is_free;
   logic [BYTES_W-1:0]   rd_bytes, need24, diff;
   logic [START_W-1:0]   rd_start;
   logic [CNT_W-1:0]     next_cnt;
   logic                 hit, take;
   logic [EXT_W-1:0]     new_end;

   fpba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_is_free = rd_data[ENTRY_W-1];
   assign rd_bytes   = rd_data[START_W +: BYTES_W];
   assign rd_start   = rd_data[START_W-1:0];
   assign need24     = need_ff[BYTES_W-1:0];
   assign diff       = rd_bytes - need24;
   assign hit        = rd_is_free && (rd_bytes >= need24);

   assign take = hit && (!pick_valid_ff ||
                         (policy_ff == FIT_BEST  && diff < pick_left_ff) ||
                         (policy_ff == FIT_WORST && diff > pick_left_ff));

   assign scan_origin = (policy_ff == FIT_NEXT && CNT_W'(cursor_ff) < count_ff) ?
                        cursor_ff : '0;
   assign next_cnt    = CNT_W'(chk_pos_ff) + 1'b1;
   assign scan_next   = (next_cnt >= count_ff) ? '0 : IDX_W'(next_cnt);

   assign new_end = EXT_W'(heap_end_ff) + EXT_W'(HEADER_BYTES) + EXT_W'(need24);

   always_comb begin
      rd_addr    = scan_next;
      chk_pos_in = chk_pos_ff;
      left_in    = left_ff;
      if (cmd.scan_start) begin
         rd_addr    = (mode_ff == MODE_FREE) ? IDX_W'(fidx_ff) : scan_origin;
         chk_pos_in = rd_addr;
         left_in    = count_ff - 1'b1;
      end else if (cmd.scan_step) begin
         chk_pos_in = scan_next;
         left_in    = left_ff - 1'b1;
      end
   end

   always_comb begin
      pick_valid_in = pick_valid_ff;
      if (cmd.load_item) begin
         pick_valid_in = 1'b0;
      end else if (cmd.scan_step && take) begin
         pick_valid_in = 1'b1;
      end
   end

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = chk_pos_ff;
      wr_data     = {1'b1, rd_bytes, rd_start};
      count_in    = count_ff;
      heap_end_in = heap_end_ff;
      cursor_in   = cursor_ff;
      case (cmd.fin)
         FIN_FREE: begin
            wr_en = 1'b1;
         end
         FIN_REUSE: begin
            wr_en     = 1'b1;
            wr_addr   = pick_idx_ff;
            wr_data   = {1'b0, pick_bytes_ff, pick_start_ff};
            cursor_in = pick_idx_ff;
         end
         FIN_GROW: begin
            wr_en       = 1'b1;
            wr_addr     = IDX_W'(count_ff);
            wr_data     = {1'b0, need24, heap_end_ff};
            count_in    = count_ff + 1'b1;
            heap_end_in = new_end[START_W-1:0];
            cursor_in   = IDX_W'(count_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= FIT_FIRST;
         limit_ff      <= '1;
         count_ff      <= '0;
         heap_end_ff   <= '0;
         cursor_ff     <= '0;
         pick_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FIT_POLICY: policy_ff <= fit_type'(csr_data[1:0]);
               CSR_HEAP_LIMIT: limit_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         count_ff      <= count_in;
         heap_end_ff   <= heap_end_in;
         cursor_ff     <= cursor_in;
         pick_valid_ff <= pick_valid_in;
         if (cmd.push_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_pos_ff <= chk_pos_in;
      left_ff    <= left_in;
      if (cmd.load_item) begin
         mode_ff <= req_mode;
         zero_ff <= (req_request_size == '0);
         need_ff <= (NEED_W'(req_request_size) + NEED_W'(3)) & ~NEED_W'(3);
         fidx_ff <= req_free_index;
      end
      if (cmd.scan_step && take) begin
         pick_idx_ff   <= chk_pos_ff;
         pick_left_ff  <= diff;
         pick_bytes_ff <= rd_bytes;
         pick_start_ff <= rd_start;
      end
      if (cmd.fin != FIN_NONE) begin
         res_status_ff <= ST_OK;
         res_index_ff  <= '0;
         res_offset_ff <= '0;
         res_reused_ff <= 1'b0;
         case (cmd.fin)
            FIN_ZERO:    res_status_ff <= ST_ZERO;
            FIN_NOMEM:   res_status_ff <= ST_NOMEM;
            FIN_BADFREE: begin
               res_status_ff <= ST_BADFREE;
               res_index_ff  <= fidx_ff;
            end
            FIN_FREE: begin
               res_index_ff  <= fidx_ff;
               res_offset_ff <= rd_start + START_W'(HEADER_BYTES);
            end
            FIN_REUSE: begin
               res_index_ff  <= 6'(pick_idx_ff);
               res_offset_ff <= pick_start_ff + START_W'(HEADER_BYTES);
               res_reused_ff <= 1'b1;
            end
            FIN_GROW: begin
               res_index_ff  <= 6'(count_ff);
               res_offset_ff <= heap_end_ff + START_W'(HEADER_BYTES);
            end
            default: begin
            end
         endcase
      end
      if (cmd.push_rsp) begin
         out_status_ff <= res_status_ff;
         out_index_ff  <= res_index_ff;
         out_offset_ff <= res_offset_ff;
         out_reused_ff <= res_reused_ff;
      end
   end

   always_comb begin
      stat.free_mode  = (mode_ff == MODE_FREE);
      stat.zero_req   = zero_ff;
      stat.oversize   = need_ff[NEED_W-1];
      stat.free_bad   = !(32'(fidx_ff) < 32'(count_ff));
      stat.count_zero = (count_ff == '0);
      stat.rd_free    = rd_is_free;
      stat.scan_stop  = hit && (policy_ff == FIT_FIRST || policy_ff == FIT_NEXT);
      stat.scan_last  = (left_ff == '0);
      stat.pick_valid = pick_valid_ff;
      stat.grow_fail  = (count_ff == CNT_W'(MAX_BLOCKS)) || (new_end > EXT_W'(limit_ff));
      stat.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_granted_index = out_index_ff;
   assign rsp_data_offset   = out_offset_ff;
   assign rsp_reused        = out_reused_ff;

   a_grow_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.fin == FIN_GROW |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("table count did not advance on grow");

   a_pick_in_table: assert property (@(posedge clock) disable iff (reset)
      pick_valid_ff |-> CNT_W'(pick_idx_ff) < count_ff)
      else $error("picked block lies beyond the table");

   a_heap_grows: assert property (@(posedge clock) disable iff (reset)
      !reset |=> heap_end_ff >= $past(heap_end_ff))
      else $error("heap end moved backwards");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.push_rsp |=> rsp_valid_ff)
      else $error("pushed result beat not shown");

endmodule

/* sv/fpba_controller.sv */
module fpba_controller
   import fpba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.free_mode) begin
               state_in = stat.free_bad ? S_RESP : S_FREE_CHK;
            end else if (stat.zero_req || stat.oversize) begin
               state_in = S_RESP;
            end else if (stat.count_zero) begin
               state_in = S_PICK;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_FREE_CHK: state_in = S_RESP;
         S_SCAN: begin
            if (stat.scan_stop || stat.scan_last) begin
               state_in = S_PICK;
            end
         end
         S_PICK: state_in = S_RESP;
         S_RESP: begin
            if (stat.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd.load_item  = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.fin        = FIN_NONE;
      cmd.push_rsp   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_DECODE: begin
            cmd.scan_start = 1'b1;
            if (stat.free_mode) begin
               if (stat.free_bad) begin
                  cmd.fin = FIN_BADFREE;
               end
            end else if (stat.zero_req) begin
               cmd.fin = FIN_ZERO;
            end else if (stat.oversize) begin
               cmd.fin = FIN_NOMEM;
            end
         end
         S_FREE_CHK: cmd.fin = stat.rd_free ? FIN_BADFREE : FIN_FREE;
         S_SCAN: cmd.scan_step = 1'b1;
         S_PICK: begin
            if (stat.pick_valid) begin
               cmd.fin = FIN_REUSE;
            end else if (stat.grow_fail) begin
               cmd.fin = FIN_NOMEM;
            end else begin
               cmd.fin = FIN_GROW;
            end
         end
         S_RESP: cmd.push_rsp = stat.slot_free;
         default: begin
         end
      endcase
   end

endmodule

/* sv/fit_policy_block_allocator_core.sv */
// Heap block allocator with selectable fit policy.
// req channel: one beat per item; mode 0 allocates request_size bytes (rounded up to a
// multiple of 4), mode 1 frees table entry free_index.
// rsp channel: exactly one beat per item, carrying status, granted_index, data_offset
// and reused.
// csr channel: always ready; index 0 writes fit_policy, index 1 writes heap_limit.
// One item is worked at a time. A free reads its table entry to check it before the
// result beat; a free whose index lies beyond the table and a zero or oversized request
// are answered straight from decode; any other allocate scans the table entries, unless
// the table is empty, then reuses the picked block or grows the heap. The scan reads the
// block table RAM one entry per cycle through its single registered read port.
// A finished result waits in an output register; req is taken again in the cycle after
// that result is staged, so with a ready receiver the next item is accepted at the edge
// that moves the result beat. While the receiver stalls a following result is held
// back until the register frees.
// Reset empties the table, zeroes the heap end and the next-fit cursor and restores
// first fit with a heap limit of all ones; no clearing pass runs.
module fit_policy_block_allocator_core
   import fpba_pkg::*;
#(
   parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input  logic  clock,
   input  logic  reset,
   fpba_req_if.sink   req,
   fpba_rsp_if.source rsp,
   fpba_csr_if.sink   csr
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr.ready = 1'b1;

   fpba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fpba_datapath #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req.mode),
      .req_request_size  (req.request_size),
      .req_free_index    (req.free_index),
      .csr_valid         (csr.valid),
      .csr_index         (csr.index),
      .csr_data          (csr.data),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_status        (rsp.status),
      .rsp_granted_index (rsp.granted_index),
      .rsp_data_offset   (rsp.data_offset),
      .rsp_reused        (rsp.reused)
   );

endmodule
